FILE: rtl/abfm_pkg.sv
// Package for the averaging background subtraction core.
// Holds payload widths, configuration register codes and reset values.
// No dependencies; compiled first.
package abfm_pkg;

  localparam int IDX_W      = 16;
  localparam int CHAN_W     = 8;
  localparam int FRAME_W    = 8;
  localparam int SCALE_W    = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DETECT_MODE,
    CFG_HIGH_SCALE,
    CFG_LOW_SCALE
  } cfg_idx_e;

  localparam logic [SCALE_W-1:0] HIGH_SCALE_RST = 14'd5120;
  localparam logic [SCALE_W-1:0] LOW_SCALE_RST  = 14'd7168;

endpackage

FILE: rtl/abfm_if.sv
// Valid/ready channel interfaces for pixel beats and mask beats.
// Depends on abfm_pkg for the payload widths.
interface abfm_pix_if;
  import abfm_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  pixel_index;
  logic [CHAN_W-1:0] chan_zero;
  logic [CHAN_W-1:0] chan_one;
  logic [CHAN_W-1:0] chan_two;
  logic              frame_end;

  modport source (output valid, pixel_index, chan_zero, chan_one, chan_two, frame_end,
                  input ready);
  modport sink   (input valid, pixel_index, chan_zero, chan_one, chan_two, frame_end,
                  output ready);
endinterface

interface abfm_mask_if;
  import abfm_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] out_index;
  logic             foreground;

  modport source (output valid, out_index, foreground, input ready);
  modport sink   (input valid, out_index, foreground, output ready);
endinterface

FILE: rtl/average_background_foreground_mask_core.sv
// Averaging background subtraction core: per-pixel sum memories, learn and detect paths.
// Depends on abfm_pkg and the channel interfaces in abfm_if.sv.
//
//   Channel   Direction  Beat contents
//   pix_i     in         pixel_index, chan_zero, chan_one, chan_two, frame_end
//   mask_o    out        out_index, foreground (detect mode only)
//   cfg_*     in         write enable, register index, write data
//
// One pixel beat is accepted per cycle while ready is high; a detect-mode result
// passes the stage 1 and stage 2 registers into the queue. Each pixel reads both
// memories at acceptance and, when learning, writes back in the next cycle; a pixel
// that directly follows a write-back to the same address takes the forwarded value.
// After reset a clearing pass zeroes each sum entry (at most 65536); no pixel is taken.
// Results wait in a four-entry queue; ready falls when the queue and pipeline hold four.
module average_background_foreground_mask_core #(
  parameter int PIXELS     = 65536,
  parameter int MAX_FRAMES = 255
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [abfm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [abfm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  abfm_pix_if.sink                        pix_i,
  abfm_mask_if.source                     mask_o
);
  import abfm_pkg::*;

  localparam int Depth     = (PIXELS > 65536) ? 65536 : PIXELS;
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int OccW      = FifoPtrW + 2;
  localparam logic [AddrW-1:0]   LastAddr   = AddrW'(Depth - 1);
  localparam logic [FRAME_W-1:0] FrameLimit = FRAME_W'(MAX_FRAMES);

  typedef logic [2:0][CHAN_W-1:0] pix_t;

  typedef struct packed {
    logic [2:0][15:0] cs;
    logic [2:0][15:0] ds;
  } sums_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fg;
  } res_t;

  // Configuration registers.
  logic                detect_q;
  logic [SCALE_W-1:0]  high_q;
  logic [SCALE_W-1:0]  low_q;

  // Learning state and clearing pass.
  logic                first_q;
  logic [FRAME_W-1:0]  frames_q;
  logic                clr_q;
  logic [AddrW-1:0]    clr_addr_q;

  // Stage 0.
  logic                accept;
  logic                in_ready;
  logic                in_range;
  logic                limited;
  logic                learn_upd;
  logic [AddrW-1:0]    addr_in;
  logic [OccW-1:0]     occ;
  pix_t                px_in;

  // Stage 1.
  logic                s1_valid_q;
  logic                s1_wr_q;
  logic                s1_det_q;
  logic                s1_first_q;
  logic                s1_empty_q;
  logic [FRAME_W-1:0]  s1_n_q;
  logic [AddrW-1:0]    s1_addr_q;
  logic [IDX_W-1:0]    s1_idx_q;
  pix_t                s1_px_q;
  logic                fwd_q;
  sums_t               fwd_sum_q;
  pix_t                fwd_prev_q;
  sums_t               sum_rd_q;
  pix_t                prev_rd_q;
  sums_t               cur_sum;
  pix_t                cur_prev;
  sums_t               new_sum;
  logic [2:0][15:0]    pn_d;
  logic [2:0][15:0]    s_d;
  logic [2:0][30:0]    hp_d;
  logic [2:0][30:0]    lp_d;

  // Memories.
  sums_t               sum_mem [Depth];
  pix_t                prev_mem [Depth];
  logic                mem_we;
  logic [AddrW-1:0]    mem_waddr;
  sums_t               mem_wsum;

  // Stage 2.
  logic                s2_valid_q;
  logic [IDX_W-1:0]    s2_idx_q;
  logic [2:0][15:0]    s2_pn_q;
  logic [2:0][15:0]    s2_s_q;
  logic [2:0][30:0]    s2_hp_q;
  logic [2:0][30:0]    s2_lp_q;
  logic                s2_fg;

  // Result queue.
  res_t                fifo_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  logic [FifoPtrW:0]   count_q;
  logic                push;
  logic                pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detect_q <= 1'b0;
      high_q   <= HIGH_SCALE_RST;
      low_q    <= LOW_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DETECT_MODE: detect_q <= cfg_data_i[0];
        CFG_HIGH_SCALE:  high_q   <= cfg_data_i[SCALE_W-1:0];
        CFG_LOW_SCALE:   low_q    <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  assign px_in     = {pix_i.chan_two, pix_i.chan_one, pix_i.chan_zero};
  assign addr_in   = pix_i.pixel_index[AddrW-1:0];
  assign in_range  = 32'(pix_i.pixel_index) < 32'(PIXELS);
  assign limited   = !first_q && (frames_q >= FrameLimit);
  assign learn_upd = !detect_q && !limited;
  assign occ       = OccW'(count_q) + OccW'(s1_valid_q) + OccW'(s2_valid_q);
  assign in_ready  = !clr_q && (occ < OccW'(FifoDepth));
  assign pix_i.ready = in_ready;
  assign accept    = pix_i.valid && in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b1;
      frames_q   <= '0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      s1_valid_q <= 1'b0;
      s1_wr_q    <= 1'b0;
      s1_det_q   <= 1'b0;
      fwd_q      <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (clr_q) begin
        if (clr_addr_q == LastAddr) begin
          clr_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
      end
      if (accept && learn_upd && pix_i.frame_end) begin
        if (first_q) begin
          first_q <= 1'b0;
        end else begin
          frames_q <= frames_q + 1'b1;
        end
      end
      s1_valid_q <= accept;
      s1_wr_q    <= accept && learn_upd && in_range;
      s1_det_q   <= accept && detect_q;
      fwd_q      <= accept && s1_wr_q && (addr_in == s1_addr_q);
      s2_valid_q <= s1_valid_q && s1_det_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q  <= addr_in;
      s1_idx_q   <= pix_i.pixel_index;
      s1_px_q    <= px_in;
      s1_first_q <= first_q;
      s1_empty_q <= (frames_q == '0) || !in_range;
      s1_n_q     <= (frames_q == '0) ? FRAME_W'(1) : frames_q;
    end
    fwd_sum_q  <= new_sum;
    fwd_prev_q <= s1_px_q;
  end

  assign mem_we    = clr_q || s1_wr_q;
  assign mem_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign mem_wsum  = clr_q ? '0 : new_sum;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sum_mem[mem_waddr] <= mem_wsum;
    end
    if (accept) begin
      sum_rd_q <= sum_mem[addr_in];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_wr_q) begin
      prev_mem[s1_addr_q] <= s1_px_q;
    end
    if (accept) begin
      prev_rd_q <= prev_mem[addr_in];
    end
  end

  assign cur_sum  = fwd_q ? fwd_sum_q : sum_rd_q;
  assign cur_prev = fwd_q ? fwd_prev_q : prev_rd_q;

  always_comb begin
    logic [CHAN_W-1:0] diff;
    logic [15:0]       dsel;
    logic [16:0]       spread;
    new_sum = cur_sum;
    for (int c = 0; c < 3; c++) begin
      diff = (s1_px_q[c] > cur_prev[c]) ? s1_px_q[c] - cur_prev[c]
                                        : cur_prev[c] - s1_px_q[c];
      if (!s1_first_q) begin
        new_sum.cs[c] = cur_sum.cs[c] + 16'(s1_px_q[c]);
        new_sum.ds[c] = cur_sum.ds[c] + 16'(diff);
      end
      s_d[c]  = s1_empty_q ? 16'd0 : cur_sum.cs[c];
      dsel    = s1_empty_q ? 16'd0 : cur_sum.ds[c];
      spread  = 17'(dsel) + 17'(s1_n_q);
      pn_d[c] = 16'(s1_px_q[c]) * 16'(s1_n_q);
      hp_d[c] = 31'(high_q) * 31'(spread);
      lp_d[c] = 31'(low_q) * 31'(spread);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_idx_q <= s1_idx_q;
    s2_pn_q  <= pn_d;
    s2_s_q   <= s_d;
    s2_hp_q  <= hp_d;
    s2_lp_q  <= lp_d;
  end

  always_comb begin
    logic [31:0] scaled;
    logic [31:0] centre;
    s2_fg = 1'b0;
    for (int c = 0; c < 3; c++) begin
      scaled = 32'({s2_pn_q[c], 8'd0});
      centre = 32'({s2_s_q[c], 8'd0});
      if ((scaled + 32'(s2_lp_q[c]) < centre) || (scaled > centre + 32'(s2_hp_q[c]))) begin
        s2_fg = 1'b1;
      end
    end
  end

  assign push = s2_valid_q;
  assign pop  = mask_o.valid && mask_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + (FifoPtrW + 1)'(push) - (FifoPtrW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{idx: s2_idx_q, fg: s2_fg};
    end
  end

  assign mask_o.valid      = (count_q != '0);
  assign mask_o.out_index  = fifo_q[rd_ptr_q].idx;
  assign mask_o.foreground = fifo_q[rd_ptr_q].fg;

  a_no_beat_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clr_q |-> !accept)
    else $error("Pixel beat accepted during the clearing pass.");

  a_queue_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni) count_q <= (FifoPtrW + 1)'(FifoDepth))
    else $error("Result queue overflow.");

  a_forward_source: assert property (
    @(posedge clk_i) disable iff (!rst_ni) fwd_q |-> $past(s1_wr_q))
    else $error("Forwarding selected without a preceding write-back.");

  a_frame_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni) frames_q <= FrameLimit)
    else $error("Learned frame count passed its limit.");

endmodule

FILE: test/tb.sv
// Testbench for average_background_foreground_mask_core: pixel beats in, mask beats out.
// Keeps its own per-pixel background model and checks every mask beat in order against it.
// Depends on abfm_pkg and the channel interfaces in abfm_if.sv.
`timescale 1ns / 100ps

module tb;
  import abfm_pkg::*;

  localparam int N_PIX         = 65536;
  localparam int FRAME_CAP     = 255;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 150;

  typedef longint unsigned u64_t;
  typedef logic [2:0][CHAN_W-1:0] rgb_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    rgb_t             chan;
    logic             frame_end;
  } pix_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             fg;
  } mask_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_we   = 1'b0;
  cfg_idx_e              cfg_idx  = CFG_DETECT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic      src_valid = 1'b0;
  pix_beat_t cur_beat  = '0;
  logic      snk_ready = 1'b0;

  abfm_pix_if  pix_bus ();
  abfm_mask_if mask_bus ();

  assign pix_bus.valid       = src_valid;
  assign pix_bus.pixel_index = cur_beat.index;
  assign pix_bus.chan_zero   = cur_beat.chan[0];
  assign pix_bus.chan_one    = cur_beat.chan[1];
  assign pix_bus.chan_two    = cur_beat.chan[2];
  assign pix_bus.frame_end   = cur_beat.frame_end;
  assign mask_bus.ready      = snk_ready;

  average_background_foreground_mask_core #(
    .PIXELS     (N_PIX),
    .MAX_FRAMES (FRAME_CAP)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_bus),
    .mask_o     (mask_bus)
  );

  // Background model state and register copies.
  bit [15:0]          sum_mem  [N_PIX][3];
  bit [15:0]          diff_mem [N_PIX][3];
  bit [CHAN_W-1:0]    prev_mem [N_PIX][3];
  int unsigned        frames_learned = 0;
  bit                 first_pending  = 1'b1;
  bit                 detect_m       = 1'b0;
  logic [SCALE_W-1:0] high_m         = HIGH_SCALE_RST;
  logic [SCALE_W-1:0] low_m          = LOW_SCALE_RST;

  pix_beat_t   pixel_backlog [$];
  mask_beat_t  mask_expected [$];
  int unsigned learn_idx [$];
  rgb_t        learn_base [$];
  int unsigned frames_planned = 0;

  bit          offering     = 1'b0;
  bit          beat_taken   = 1'b0;
  bit          result_taken = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  bit          src_idle_on  = 1'b1;
  bit          snk_idle_on  = 1'b1;
  bit          pressure_go  = 1'b0;
  bit          hold_active  = 1'b0;

  int unsigned cycle_count  = 0;
  int unsigned pixels_in    = 0;
  int unsigned masks_out    = 0;
  int unsigned fg_out       = 0;
  int unsigned held_cycles  = 0;
  int unsigned errors       = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit chan_in_range(u64_t p, u64_t s, u64_t d, u64_t n);
    u64_t scaled;
    u64_t centre;
    u64_t spread;
    u64_t hi;
    u64_t lo;
    scaled = p * n * 256;
    centre = s * 256;
    spread = d + n;
    hi     = high_m;
    lo     = low_m;
    return (scaled + lo * spread >= centre) && (scaled <= centre + hi * spread);
  endfunction

  function automatic void update_background_model(pix_beat_t b);
    mask_beat_t      want;
    u64_t            n;
    bit              empty;
    bit [CHAN_W-1:0] diff;
    int unsigned     idx;
    idx = b.index;
    if (!detect_m) begin
      if (!first_pending && frames_learned >= FRAME_CAP) return;
      if (idx < N_PIX) begin
        for (int c = 0; c < 3; c++) begin
          if (!first_pending) begin
            diff = (b.chan[c] > prev_mem[idx][c]) ? b.chan[c] - prev_mem[idx][c]
                                                  : prev_mem[idx][c] - b.chan[c];
            sum_mem[idx][c]  += b.chan[c];
            diff_mem[idx][c] += diff;
          end
          prev_mem[idx][c] = b.chan[c];
        end
      end
      if (b.frame_end) begin
        if (first_pending) first_pending = 1'b0;
        else frames_learned++;
      end
    end else begin
      n     = frames_learned;
      empty = (n == 0) || (idx >= N_PIX);
      if (n == 0) n = 1;
      want.index = b.index;
      want.fg    = 1'b0;
      for (int c = 0; c < 3; c++) begin
        if (!chan_in_range(b.chan[c], empty ? 0 : sum_mem[idx][c],
                           empty ? 0 : diff_mem[idx][c], n)) begin
          want.fg = 1'b1;
        end
      end
      mask_expected.push_back(want);
    end
  endfunction

  function automatic void report_error(string msg);
    errors++;
    if (errors <= 10) $display("[%0t] %s", $realtime, msg);
  endfunction

  function automatic pix_beat_t mk_beat(int unsigned idx, int unsigned c0, int unsigned c1,
                                        int unsigned c2, bit fe);
    pix_beat_t b;
    b.index     = idx[IDX_W-1:0];
    b.chan[0]   = c0[CHAN_W-1:0];
    b.chan[1]   = c1[CHAN_W-1:0];
    b.chan[2]   = c2[CHAN_W-1:0];
    b.frame_end = fe;
    return b;
  endfunction

  function automatic logic [CHAN_W-1:0] jitter(logic [CHAN_W-1:0] centre, int unsigned spread);
    int v;
    v = int'(centre) + int'($urandom_range(0, 2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[CHAN_W-1:0];
  endfunction

  function automatic pix_beat_t learn_pixel(int unsigned slot, bit last);
    pix_beat_t b;
    b.index = IDX_W'(learn_idx[slot]);
    for (int c = 0; c < 3; c++) begin
      b.chan[c] = ($urandom_range(0, 7) == 0) ? CHAN_W'($urandom)
                                              : jitter(learn_base[slot][c], 10);
    end
    b.frame_end = last;
    return b;
  endfunction

  function automatic void queue_learn_frames(int unsigned count, int unsigned max_len);
    int unsigned len;
    int unsigned slot;
    repeat (count) begin
      len  = $urandom_range(1, max_len);
      slot = $urandom_range(0, learn_idx.size() - 1);
      for (int k = 0; k < len; k++) begin
        if (k != 0 && $urandom_range(0, 3) != 0) slot = $urandom_range(0, learn_idx.size() - 1);
        pixel_backlog.push_back(learn_pixel(slot, k == len - 1));
      end
      frames_planned++;
    end
  endfunction

  function automatic void queue_detect(int unsigned count);
    pix_beat_t   b;
    int unsigned slot;
    int unsigned spread;
    repeat (count) begin
      slot   = $urandom_range(0, learn_idx.size() - 1);
      spread = $urandom_range(0, 60);
      if ($urandom_range(0, 3) == 0) begin
        b.index = IDX_W'($urandom);
        for (int c = 0; c < 3; c++) b.chan[c] = CHAN_W'($urandom);
      end else begin
        b.index = IDX_W'(learn_idx[slot]);
        for (int c = 0; c < 3; c++) b.chan[c] = jitter(learn_base[slot][c], spread);
      end
      b.frame_end = ($urandom_range(0, 7) == 0);
      pixel_backlog.push_back(b);
    end
  endfunction

  task automatic write_reg(cfg_idx_e r, int unsigned v);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= r;
    cfg_data <= v[CFG_DATA_W-1:0];
    case (r)
      CFG_DETECT_MODE: detect_m = v[0];
      CFG_HIGH_SCALE:  high_m   = v[SCALE_W-1:0];
      CFG_LOW_SCALE:   low_m    = v[SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (pixel_backlog.size() != 0 || offering || mask_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count % 256 == 0) begin
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d mask beats outstanding.", cycle_count,
               mask_expected.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && src_valid) begin
      if (pix_bus.ready) begin
        update_background_model(cur_beat);
        beat_taken = 1'b1;
        pixels_in++;
      end else begin
        held_cycles++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (beat_taken) begin
        beat_taken = 1'b0;
        offering   = 1'b0;
        gap_left   = src_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pixel_backlog.size() != 0) begin
          cur_beat <= pixel_backlog.pop_front();
          offering = 1'b1;
        end
      end
      src_valid <= offering;
    end
  end

  always @(posedge clk_i) begin : mask_check
    mask_beat_t want;
    if (rst_ni && mask_bus.valid && snk_ready) begin
      result_taken = 1'b1;
      masks_out++;
      if (mask_bus.foreground === 1'b1) fg_out++;
      if (mask_expected.size() == 0) begin
        report_error($sformatf("unexpected mask beat: index %0d foreground %0b",
                               mask_bus.out_index, mask_bus.foreground));
      end else begin
        want = mask_expected.pop_front();
        if (mask_bus.out_index !== want.index || mask_bus.foreground !== want.fg) begin
          report_error($sformatf(
            "mask beat mismatch: expected index %0d foreground %0b, got %0d %0b",
            want.index, want.fg, mask_bus.out_index, mask_bus.foreground));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        result_taken = 1'b0;
        stall_left   = snk_idle_on ? $urandom_range(0, 8) : 0;
      end
      if (hold_active) begin
        snk_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        snk_ready <= 1'b0;
      end else begin
        snk_ready <= 1'b1;
      end
    end
  end

  initial begin : long_hold
    while (!pressure_go) @(posedge clk_i);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_active = 1'b0;
  end

  initial begin : stimulus
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (pix_bus.ready !== 1'b1) @(negedge clk_i);

    learn_idx  = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00};
    learn_base = '{24'h000000, 24'hFFFFFF};
    while (learn_base.size() < 12) begin
      if (learn_idx.size() < 12) learn_idx.push_back($urandom_range(0, N_PIX - 1));
      learn_base.push_back(rgb_t'($urandom));
    end

    // Empty model: every pixel is judged with one frame and zero sums.
    write_reg(CFG_DETECT_MODE, 1);
    write_reg(CFG_HIGH_SCALE, HIGH_SCALE_RST);
    write_reg(CFG_LOW_SCALE, LOW_SCALE_RST);
    pixel_backlog.push_back(mk_beat(0, 0, 0, 0, 1'b1));
    pixel_backlog.push_back(mk_beat(16'hFFFF, 255, 255, 255, 1'b0));
    pixel_backlog.push_back(mk_beat(1, 20, 20, 20, 1'b0));
    pixel_backlog.push_back(mk_beat(2, 21, 20, 20, 1'b1));
    pixel_backlog.push_back(mk_beat(3, 20, 21, 20, 1'b0));
    pixel_backlog.push_back(mk_beat(4, 20, 20, 21, 1'b0));
    settle();
    write_reg(CFG_HIGH_SCALE, 16383);
    write_reg(CFG_LOW_SCALE, 0);
    pixel_backlog.push_back(mk_beat(5, 63, 63, 63, 1'b0));
    pixel_backlog.push_back(mk_beat(6, 64, 0, 0, 1'b0));
    settle();
    write_reg(CFG_HIGH_SCALE, 0);
    pixel_backlog.push_back(mk_beat(7, 0, 0, 0, 1'b0));
    pixel_backlog.push_back(mk_beat(8, 0, 1, 0, 1'b0));
    settle();

    // The first learnt frame writes every pixel that later frames will revisit.
    write_reg(CFG_DETECT_MODE, 0);
    foreach (learn_idx[s]) begin
      pixel_backlog.push_back(mk_beat(learn_idx[s], learn_base[s][0], learn_base[s][1],
                                      learn_base[s][2], s == learn_idx.size() - 1));
    end
    queue_learn_frames(12, 5);
    settle();

    write_reg(CFG_DETECT_MODE, 1);
    write_reg(CFG_HIGH_SCALE,
              $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 16383));
    write_reg(CFG_LOW_SCALE,
              $urandom_range(0, 1) ? $urandom_range(0, 1023) : $urandom_range(0, 16383));
    queue_detect(60);
    settle();

    write_reg(CFG_DETECT_MODE, 0);
    queue_learn_frames(15, 5);
    settle();

    write_reg(CFG_DETECT_MODE, 1);
    write_reg(CFG_HIGH_SCALE, 16383);
    write_reg(CFG_LOW_SCALE, 16383);
    queue_detect(25);
    settle();
    write_reg(CFG_HIGH_SCALE, 0);
    write_reg(CFG_LOW_SCALE, 0);
    queue_detect(25);
    settle();

    write_reg(CFG_HIGH_SCALE, HIGH_SCALE_RST);
    write_reg(CFG_LOW_SCALE, LOW_SCALE_RST);
    queue_detect(120);
    pressure_go = 1'b1;
    settle();

    // Run the frame count up to its cap; the frames after it must leave the model alone.
    write_reg(CFG_DETECT_MODE, 0);
    queue_learn_frames(FRAME_CAP - frames_planned, 1);
    queue_learn_frames(6, 2);
    settle();

    write_reg(CFG_DETECT_MODE, 1);
    write_reg(CFG_HIGH_SCALE, $urandom_range(0, 2047));
    write_reg(CFG_LOW_SCALE, $urandom_range(0, 2047));
    queue_detect(50);
    settle();

    $display("Covered %0d pixel beats over learn and detect phases, %0d frames learnt (cap %0d).",
             pixels_in, frames_learned, FRAME_CAP);
    $display("Checked %0d mask beats (%0d foreground); input held off for %0d cycles; %0d errors.",
             masks_out, fg_out, held_cycles, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
